// ===== src/ggnh_pkg.sv =====
// Shared constants, types and helpers for the greedy geographic next-hop block.
`timescale 1ns / 1ps
package ggnh_pkg;

	localparam int NEIGHBOR_SLOTS = 32;
	localparam int COORD_BITS     = 16;
	localparam int ID_BITS        = 16;
	localparam int SLOT_FIELD_BITS = 5;

	localparam int SLOT_BITS = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
	localparam int CNT_BITS  = $clog2(NEIGHBOR_SLOTS + 1);
	localparam int MAG_BITS  = COORD_BITS + 1;
	localparam int SQ_BITS   = 2 * MAG_BITS;
	localparam int DIST_BITS = SQ_BITS + 1;
	localparam int ENTRY_BITS = ID_BITS + 2 * COORD_BITS;

	localparam int IN_FIELD_BITS = SLOT_FIELD_BITS + ID_BITS + 2 * COORD_BITS;
	localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

	localparam logic [ID_BITS-1:0] BROADCAST_ID = '1;

	// action codes
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_ROUTE = 2'd2;

	// verdict codes
	localparam logic [1:0] VERDICT_LOCAL = 2'd0;
	localparam logic [1:0] VERDICT_BCAST = 2'd1;
	localparam logic [1:0] VERDICT_FWD   = 2'd2;
	localparam logic [1:0] VERDICT_DROP  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_SELF_ID = 2'd0;
	localparam logic [1:0] REG_SELF_X  = 2'd1;
	localparam logic [1:0] REG_SELF_Y  = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [MAG_BITS-1:0] mag_t;
	typedef logic [DIST_BITS-1:0] dist_t;

	typedef struct packed {
		logic               self;  // entry is this node's own position
		logic [ID_BITS-1:0] node;
	} tag_t;

	// absolute difference of two signed coordinates
	function automatic mag_t abs_diff(input coord_t a, input coord_t b);
		logic signed [MAG_BITS-1:0] d;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		return d[MAG_BITS-1] ? mag_t'(-d) : mag_t'(d);
	endfunction

endpackage

// ===== src/greedy_geographic_next_hop.sv =====
// Greedy geographic next-hop selector with a memory-held neighbor table.
`timescale 1ns / 1ps
// - Input items arrive on s_tvalid/s_tready with s_tuser = action and s_tdata =
//   {pos_y, pos_x, node_id, slot}. Write and clear items update the neighbor
//   table in the accept cycle and give no result.
// - Route items give one result on m_tvalid/m_tready: m_tuser = verdict,
//   m_tdata = next_hop (zero unless the verdict is forward).
//   A route for this node or for the broadcast id goes straight to the done
//   state, which loads the result once the output register is free; the next
//   item is accepted after that. Any other route scans the table: one issue
//   for this node's own distance, then one table read per slot through the
//   distance pipeline (absolute difference, square, add-and-compare); the
//   drain state waits for the pipeline to empty, then the done state loads
//   the result and the next item follows. Every slot is read, but empty
//   slots are not compared. The table has a single read port, so slots are
//   read in turn.
// - Write and clear leave the block idle; items follow back to back.
// - Configuration (self_id, self_x, self_y) is written through cfg_valid /
//   cfg_index / cfg_data and is always ready; write it only while idle.
// - Reset clears all slot valid bits, the config registers and the output
//   valid bit; a slot enters the comparison only after a write set its valid bit.
// - A stalled receiver holds the result in the output register; the block
//   keeps accepting write and clear items and may finish one more route,
//   which then waits for the output register to drain.
module greedy_geographic_next_hop (
	input  logic                                clk,
	input  logic                                arst_n,
	// input items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ggnh_pkg::IN_DATA_BITS-1:0]   s_tdata,  // slot, node_id, pos_x, pos_y, zero pad
	input  logic [1:0]                          s_tuser,  // action
	// result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ggnh_pkg::ID_BITS-1:0]        m_tdata,  // next_hop
	output logic [1:0]                          m_tuser,  // verdict
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [ggnh_pkg::ID_BITS-1:0]        cfg_data
);
	import ggnh_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;

	// configuration
	logic [ID_BITS-1:0] self_id_q;
	coord_t             self_x_q;
	coord_t             self_y_q;

	// unpack the input item
	logic [SLOT_FIELD_BITS-1:0] in_slot;
	logic [ID_BITS-1:0]         in_node;
	coord_t                     in_x;
	coord_t                     in_y;
	logic                       in_fire;
	logic                       slot_ok;
	logic [SLOT_BITS-1:0]       wr_addr;

	assign in_slot = s_tdata[SLOT_FIELD_BITS-1:0];
	assign in_node = s_tdata[SLOT_FIELD_BITS +: ID_BITS];
	assign in_x    = s_tdata[SLOT_FIELD_BITS + ID_BITS +: COORD_BITS];
	assign in_y    = s_tdata[SLOT_FIELD_BITS + ID_BITS + COORD_BITS +: COORD_BITS];
	assign in_fire = s_tvalid && s_tready;
	assign slot_ok = int'(in_slot) < NEIGHBOR_SLOTS;
	assign wr_addr = SLOT_BITS'(in_slot);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// neighbor table: valid bits in flops, entries in a synchronous memory
	logic [NEIGHBOR_SLOTS-1:0] valid_q;
	logic [ENTRY_BITS-1:0]     tbl_mem [NEIGHBOR_SLOTS];
	logic [ENTRY_BITS-1:0]     rd_data_s1;
	logic                      tbl_we;
	logic [SLOT_BITS-1:0]      rd_addr;

	assign tbl_we = in_fire && (s_tuser == ACT_WRITE) && slot_ok;

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[wr_addr] <= {in_y, in_x, in_node};
		end
		rd_data_s1 <= tbl_mem[rd_addr];
	end

	// route bookkeeping
	coord_t               dest_x_q;
	coord_t               dest_y_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 scan_q;       // result comes from the scan
	logic [1:0]           fixed_verdict_q;
	dist_t                best_q;
	logic                 found_q;
	logic [ID_BITS-1:0]   hop_q;

	assign rd_addr = SLOT_BITS'(cnt_q - CNT_BITS'(1));

	// scan pipeline
	logic   act_s1;
	logic   self_s1;
	logic   act_s2;
	logic   act_s3;
	tag_t   tag_s2;
	mag_t   abs_x_s2;
	mag_t   abs_y_s2;
	tag_t   tag_s3;
	logic [SQ_BITS-1:0] sq_x_s3;
	logic [SQ_BITS-1:0] sq_y_s3;
	coord_t cand_x;
	coord_t cand_y;
	dist_t  dist_s3;
	logic   pipe_busy;
	logic   issue;

	assign issue     = (state_q == ST_SCAN);
	assign cand_x    = self_s1 ? self_x_q : rd_data_s1[ID_BITS +: COORD_BITS];
	assign cand_y    = self_s1 ? self_y_q : rd_data_s1[ID_BITS + COORD_BITS +: COORD_BITS];
	assign dist_s3   = DIST_BITS'(sq_x_s3) + DIST_BITS'(sq_y_s3);
	assign pipe_busy = act_s1 || act_s2 || act_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1  <= 1'b0;
			self_s1 <= 1'b0;
			act_s2  <= 1'b0;
			act_s3  <= 1'b0;
		end else begin
			// the self entry goes first, then one slot per cycle
			act_s1  <= issue && ((cnt_q == '0) || valid_q[rd_addr]);
			self_s1 <= issue && (cnt_q == '0);
			act_s2  <= act_s1;
			act_s3  <= act_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2.self <= self_s1;
		tag_s2.node <= rd_data_s1[ID_BITS-1:0];
		abs_x_s2    <= abs_diff(cand_x, dest_x_q);
		abs_y_s2    <= abs_diff(cand_y, dest_y_q);
		tag_s3      <= tag_s2;
		sq_x_s3     <= abs_x_s2 * abs_x_s2;
		sq_y_s3     <= abs_y_s2 * abs_y_s2;
	end

	// add-and-compare: the self entry seeds the best distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (act_s3) begin
			if (tag_s3.self) begin
				found_q <= 1'b0;
			end else if (dist_s3 < best_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_s3 && (tag_s3.self || (dist_s3 < best_q))) begin
			best_q <= dist_s3;
			hop_q  <= tag_s3.node;
		end
	end

	// control: accept, scan, drain, hand over to the output register
	logic [1:0]         out_verdict;
	logic [ID_BITS-1:0] out_hop;
	logic               out_load;

	assign out_verdict = scan_q ? (found_q ? VERDICT_FWD : VERDICT_DROP) : fixed_verdict_q;
	assign out_hop     = (scan_q && found_q) ? hop_q : '0;
	assign out_load    = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			scan_q          <= 1'b0;
			fixed_verdict_q <= VERDICT_LOCAL;
			valid_q         <= '0;
			self_id_q       <= '0;
			self_x_q        <= '0;
			self_y_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SELF_ID: self_id_q <= cfg_data;
					REG_SELF_X:  self_x_q  <= coord_t'(cfg_data);
					REG_SELF_Y:  self_y_q  <= coord_t'(cfg_data);
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (s_tuser)
							ACT_WRITE: begin
								if (slot_ok) begin
									valid_q[wr_addr] <= 1'b1;
								end
							end
							ACT_CLEAR: begin
								if (slot_ok) begin
									valid_q[wr_addr] <= 1'b0;
								end
							end
							ACT_ROUTE: begin
								// self check before broadcast check
								if (in_node == self_id_q) begin
									scan_q          <= 1'b0;
									fixed_verdict_q <= VERDICT_LOCAL;
									state_q         <= ST_DONE;
								end else if (in_node == BROADCAST_ID) begin
									scan_q          <= 1'b0;
									fixed_verdict_q <= VERDICT_BCAST;
									state_q         <= ST_DONE;
								end else begin
									scan_q  <= 1'b1;
									cnt_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (cnt_q == CNT_BITS'(NEIGHBOR_SLOTS)) begin
						state_q <= ST_DRAIN;
					end
					cnt_q <= cnt_q + CNT_BITS'(1);
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (s_tuser == ACT_ROUTE)) begin
			dest_x_q <= in_x;
			dest_y_q <= in_y;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser <= out_verdict;
			m_tdata <= out_hop;
		end
	end

	// checks
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pipe_busy)
		else $error("scan pipeline busy while accepting items");

	a_hop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != VERDICT_FWD)) |-> (m_tdata == '0))
		else $error("next_hop nonzero without forward verdict");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the done state");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= CNT_BITS'(NEIGHBOR_SLOTS)))
		else $error("scan counter past table end");

	a_self_first: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && (cnt_q == '0)) |=> (self_s1 && act_s1))
		else $error("scan did not start with own distance");

endmodule
